// ===== design/hti_pkg.sv =====
// ---------------------------------------------------------------------------
// hti_pkg
// Shared types and fixed constants of the heightmap triangle interpolator.
// ---------------------------------------------------------------------------
`default_nettype none

package hti_pkg;

    typedef enum logic [1:0] {
        MODE_WRITE   = 2'd0,
        MODE_HEIGHT  = 2'd1,
        MODE_SLOPE_X = 2'd2,
        MODE_SLOPE_Y = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_ORIGIN_X  = 3'd0,
        REG_ORIGIN_Y  = 3'd1,
        REG_CELL_SIZE = 3'd2,
        REG_CELLS_X   = 3'd3,
        REG_CELLS_Y   = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SLOPE_GO,
        ST_SLOPE_WAIT,
        ST_FINISH
    } state_t;

    localparam int CS_W      = 31;
    localparam int FRAC_W    = 16;
    localparam int DIV_W     = 48;   // 32 integer bits + 16 fraction bits
    localparam int DIV_STEPS = 48;

    localparam logic [16:0] ONE_Q16  = 17'h1_0000;
    localparam logic [30:0] CS_RESET = 31'h0001_0000;
    localparam logic [8:0]  CNT_RESET = 9'd256;

endpackage

`default_nettype wire

// ===== design/hti_cfg_if.sv =====
// ---------------------------------------------------------------------------
// hti_cfg_if
// Register write channel: index and write data with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface hti_cfg_if;
    import hti_pkg::*;

    logic        valid;
    logic        ready;
    reg_idx_t    index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/hti_in_if.sv =====
// ---------------------------------------------------------------------------
// hti_in_if
// Request channel: node writes and position queries.
// ---------------------------------------------------------------------------
`default_nettype none

interface hti_in_if;
    import hti_pkg::*;

    logic               valid;
    logic               ready;
    mode_t              mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] height_in;

    modport source (output valid, mode, coord_x, coord_y, height_in, input ready);
    modport sink   (input valid, mode, coord_x, coord_y, height_in, output ready);
endinterface

`default_nettype wire

// ===== design/hti_out_if.sv =====
// ---------------------------------------------------------------------------
// hti_out_if
// Result channel: interpolated height or slope and inside flag.
// ---------------------------------------------------------------------------
`default_nettype none

interface hti_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic               inside_res;

    modport source (output valid, value_out, inside_res, input ready);
    modport sink   (input valid, value_out, inside_res, output ready);
endinterface

`default_nettype wire

// ===== design/hti_div.sv =====
// ---------------------------------------------------------------------------
// hti_div
// Restoring radix-2 divider, one quotient bit per cycle, 48-bit dividend
// by 31-bit divisor. done pulses in the cycle after the last step.
// ---------------------------------------------------------------------------
`default_nettype none

module hti_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [hti_pkg::DIV_W-1:0]  dividend,
    input  wire logic [hti_pkg::CS_W-1:0]   divisor,
    output logic                            done,
    output logic [hti_pkg::DIV_W-1:0]       quot,
    output logic [hti_pkg::CS_W-1:0]        rem
);
    import hti_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [CS_W-1:0]   rem_reg, rem_next;
    logic [CS_W-1:0]   dvs_reg, dvs_next;

    logic [CS_W:0]     rem_sh;
    logic              ge;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIV_W-1]};
        ge        = rem_sh >= {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DIV_W-2:0], ge};
            rem_next = ge ? CS_W'(rem_sh - {1'b0, dvs_reg}) : CS_W'(rem_sh);
            cnt_next = STEP_W'(cnt_reg + 1'b1);
            if (cnt_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

// ===== design/heightmap_triangle_interpolator.sv =====
// ---------------------------------------------------------------------------
// heightmap_triangle_interpolator
// Height grid with barycentric triangle lookup of height and slope.
// ---------------------------------------------------------------------------
// Usage:
//   cfg  : register writes (origin_x, origin_y, cell_size, cells_x, cells_y),
//          always ready; write only while no request is in flight.
//   req  : one beat per item. mode WRITE stores height_in at node
//          (coord_x, coord_y) and gives no result. Other modes
//          query the world position (coord_x, coord_y) in Q16.16.
//   rsp  : one beat per query: value_out (Q16.16, saturated) and inside_res.
// Path per request (ready only in IDLE, so not while a query is in flight):
//   write                                 stored from IDLE, no result
//   outside by offset or zero cell size   IDLE straight to FINISH
//   outside by cell index                 both divisions, then FINISH
//   height query   divisions, corner node reads, MUL1 to MUL3, FINISH
//   slope query    height path up to the reads, then a second division
//                  of the height difference by cell_size
// Reset clears control state, presets registers; node heights are undefined
// until written, there is no clearing pass. A finished result sits in the
// rsp register; the next request is taken while it waits, and a query
// stalls in FINISH only if the previous result has still not been taken.
// ---------------------------------------------------------------------------
`default_nettype none

module heightmap_triangle_interpolator #(
    parameter int MAX_CELLS = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hti_cfg_if.sink   cfg,
    hti_in_if.sink    req,
    hti_out_if.source rsp
);
    import hti_pkg::*;

    localparam int ROW    = MAX_CELLS + 1;
    localparam int NODES  = ROW * ROW;
    localparam int ADDR_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(MAX_CELLS + 1);

    // configuration
    logic [31:0]     origin_x_reg, origin_y_reg;
    logic [CS_W-1:0] cell_size_reg;
    logic [8:0]      cells_x_reg, cells_y_reg;

    // control
    state_t state_reg, state_next;
    logic [2:0] rd_cnt_reg, rd_cnt_next;

    // datapath
    mode_t                mode_reg;
    logic [FRAC_W-1:0]    fx_reg, fy_reg;
    logic [ADDR_W-1:0]    base_reg;
    logic signed [31:0]   h_reg [4];   // h00, h10, h01, h11
    logic signed [50:0]   prod_reg;
    logic signed [52:0]   acc_reg;
    logic                 sneg_reg;
    logic signed [31:0]   res_val_reg;
    logic                 res_in_reg;
    logic signed [31:0]   out_val_reg;
    logic                 out_in_reg;
    logic                 out_valid_reg;

    // memory
    logic [31:0]       mem [NODES];
    logic [31:0]       rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;

    // divider lanes
    logic              div_start_x, div_start_y;
    logic [DIV_W-1:0]  div_dvd_x;
    logic              div_done_x, div_done_y;
    logic [DIV_W-1:0]  quo_x, quo_y;
    logic [CS_W-1:0]   rem_x, rem_y;

    // combinational helpers
    logic [CNT_W-1:0]   ncx, ncy;
    logic               req_acc, rsp_acc, out_load;
    logic signed [32:0] dx, dy;
    logic               q_out_early, q_out_late;
    logic               lower;
    logic signed [31:0] base_h;
    logic signed [32:0] d1, d2, sd;
    logic [16:0]        f1, f2;
    logic [31:0]        smag;
    logic signed [52:0] sum_h;
    logic signed [36:0] shr_h;
    logic signed [31:0] sat_h;
    logic [48:0]        qr;
    logic               round_up;
    logic signed [31:0] sat_s;
    logic [1:0]         cap_idx;

    assign ncx = (32'(cells_x_reg) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(cells_x_reg);
    assign ncy = (32'(cells_y_reg) > 32'(MAX_CELLS)) ? CNT_W'(MAX_CELLS) : CNT_W'(cells_y_reg);

    assign req_acc  = req.valid && req.ready;
    assign rsp_acc  = rsp.valid && rsp.ready;
    assign out_load = (state_reg == ST_FINISH) && (!out_valid_reg || rsp.ready);

    assign dx = {req.coord_x[31], req.coord_x} - {origin_x_reg[31], origin_x_reg};
    assign dy = {req.coord_y[31], req.coord_y} - {origin_y_reg[31], origin_y_reg};
    assign q_out_early = (cell_size_reg == '0) || dx[32] || dy[32];
    assign q_out_late  = (quo_x[DIV_W-1:FRAC_W] >= 32'(ncx)) ||
                         (quo_y[DIV_W-1:FRAC_W] >= 32'(ncy));

    // node write: index taken unsigned, ignored past the cells in use
    assign mem_we = req_acc && (req.mode == MODE_WRITE) &&
                    (req.coord_x <= 32'(ncx)) && (req.coord_y <= 32'(ncy));
    assign mem_waddr = ADDR_W'(ADDR_W'(req.coord_y[CNT_W-1:0]) * ADDR_W'(ROW)
                               + ADDR_W'(req.coord_x[CNT_W-1:0]));

    always_comb
    begin
        case (rd_cnt_reg[1:0])
            2'd0:    mem_raddr = base_reg;
            2'd1:    mem_raddr = ADDR_W'(base_reg + ADDR_W'(1));
            2'd2:    mem_raddr = ADDR_W'(base_reg + ADDR_W'(ROW));
            default: mem_raddr = ADDR_W'(base_reg + ADDR_W'(ROW + 1));
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= req.height_in;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    // triangle selection: lower when fx + fy < 1.0
    assign lower  = (17'(fx_reg) + 17'(fy_reg)) < ONE_Q16;
    assign base_h = lower ? h_reg[0] : h_reg[3];
    assign d1     = lower ? (33'(h_reg[1]) - 33'(h_reg[0])) : (33'(h_reg[2]) - 33'(h_reg[3]));
    assign d2     = lower ? (33'(h_reg[2]) - 33'(h_reg[0])) : (33'(h_reg[1]) - 33'(h_reg[3]));
    assign f1     = lower ? 17'(fx_reg) : 17'(ONE_Q16 - 17'(fx_reg));
    assign f2     = lower ? 17'(fy_reg) : 17'(ONE_Q16 - 17'(fy_reg));

    always_comb
    begin
        if (mode_reg == MODE_SLOPE_X)
            sd = lower ? (33'(h_reg[1]) - 33'(h_reg[0])) : (33'(h_reg[3]) - 33'(h_reg[2]));
        else
            sd = lower ? (33'(h_reg[2]) - 33'(h_reg[0])) : (33'(h_reg[3]) - 33'(h_reg[1]));
    end
    assign smag = sd[32] ? 32'(-sd) : 32'(sd);

    // height: round at bit 15, floor shift, saturate
    assign sum_h = acc_reg + 53'(prod_reg);
    assign shr_h = 37'(sum_h >>> FRAC_W);
    assign sat_h = (shr_h > 37'sh0_7FFF_FFFF)  ? 32'sh7FFF_FFFF :
                   (shr_h < -37'sh0_8000_0000) ? 32'sh8000_0000 : 32'(shr_h);

    // slope: round half away from zero, saturate
    assign round_up = {rem_x, 1'b0} >= {1'b0, cell_size_reg};
    assign qr       = 49'(quo_x) + 49'(round_up);
    always_comb
    begin
        if (!sneg_reg)
            sat_s = (qr > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(qr);
        else
            sat_s = (qr > 49'h0_8000_0000) ? 32'sh8000_0000 : 32'(-qr[31:0]);
    end

    assign div_dvd_x = (state_reg == ST_SLOPE_GO) ? {smag, FRAC_W'(0)}
                                                  : {dx[31:0], FRAC_W'(0)};

    hti_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_x),
        .dividend (div_dvd_x),
        .divisor  (cell_size_reg),
        .done     (div_done_x),
        .quot     (quo_x),
        .rem      (rem_x)
    );

    hti_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_y),
        .dividend ({dy[31:0], FRAC_W'(0)}),
        .divisor  (cell_size_reg),
        .done     (div_done_y),
        .quot     (quo_y),
        .rem      (rem_y)
    );

    // next state
    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_acc && (req.mode != MODE_WRITE))
                    state_next = q_out_early ? ST_FINISH : ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done_x && div_done_y)
                begin
                    state_next  = q_out_late ? ST_FINISH : ST_READ;
                    rd_cnt_next = '0;
                end
            end
            ST_READ:
            begin
                rd_cnt_next = 3'(rd_cnt_reg + 3'd1);
                if (rd_cnt_reg == 3'd4)
                    state_next = (mode_reg == MODE_HEIGHT) ? ST_MUL1 : ST_SLOPE_GO;
            end
            ST_MUL1:       state_next = ST_MUL2;
            ST_MUL2:       state_next = ST_MUL3;
            ST_MUL3:       state_next = ST_FINISH;
            ST_SLOPE_GO:   state_next = ST_SLOPE_WAIT;
            ST_SLOPE_WAIT:
            begin
                if (div_done_x)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        req.ready   = 1'b0;
        cfg.ready   = 1'b1;
        div_start_x = 1'b0;
        div_start_y = 1'b0;
        mem_re      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req.ready   = 1'b1;
                div_start_x = req.valid && (req.mode != MODE_WRITE) && !q_out_early;
                div_start_y = div_start_x;
            end
            ST_READ:       mem_re = !rd_cnt_reg[2];
            ST_SLOPE_GO:   div_start_x = 1'b1;
            ST_DIVIDE, ST_MUL1, ST_MUL2, ST_MUL3, ST_SLOPE_WAIT, ST_FINISH: ;
            default: ;
        endcase
    end

    assign cap_idx = 2'(rd_cnt_reg - 3'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            cell_size_reg <= CS_RESET;
            cells_x_reg   <= CNT_RESET;
            cells_y_reg   <= CNT_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp_acc)
                out_valid_reg <= 1'b0;
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_ORIGIN_X:  origin_x_reg  <= cfg.data;
                    REG_ORIGIN_Y:  origin_y_reg  <= cfg.data;
                    REG_CELL_SIZE: cell_size_reg <= cfg.data[CS_W-1:0];
                    REG_CELLS_X:   cells_x_reg   <= cfg.data[8:0];
                    REG_CELLS_Y:   cells_y_reg   <= cfg.data[8:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            mode_reg    <= req.mode;
            res_val_reg <= '0;
            res_in_reg  <= 1'b0;
        end
        if ((state_reg == ST_DIVIDE) && div_done_x && div_done_y)
        begin
            fx_reg   <= quo_x[FRAC_W-1:0];
            fy_reg   <= quo_y[FRAC_W-1:0];
            base_reg <= ADDR_W'(ADDR_W'(quo_y[FRAC_W +: CNT_W]) * ADDR_W'(ROW)
                                + ADDR_W'(quo_x[FRAC_W +: CNT_W]));
        end
        if ((state_reg == ST_READ) && (rd_cnt_reg != 3'd0))
            h_reg[cap_idx] <= rd_data_reg;
        if (state_reg == ST_MUL1)
        begin
            prod_reg <= $signed({1'b0, f1}) * d1;
            acc_reg  <= (53'(base_h) <<< FRAC_W) + 53'sd32768;
        end
        if (state_reg == ST_MUL2)
        begin
            prod_reg <= $signed({1'b0, f2}) * d2;
            acc_reg  <= sum_h;
        end
        if (state_reg == ST_MUL3)
        begin
            res_val_reg <= sat_h;
            res_in_reg  <= 1'b1;
        end
        if (state_reg == ST_SLOPE_GO)
            sneg_reg <= sd[32];
        if ((state_reg == ST_SLOPE_WAIT) && div_done_x)
        begin
            res_val_reg <= sat_s;
            res_in_reg  <= 1'b1;
        end
        if (out_load)
        begin
            out_val_reg <= res_val_reg;
            out_in_reg  <= res_in_reg;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.value_out  = out_val_reg;
    assign rsp.inside_res = out_in_reg;

    // ---- assertions ----
    a_no_mem_collision: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("node memory read and write in the same cycle");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done_x |-> (state_reg == ST_DIVIDE || state_reg == ST_SLOPE_WAIT))
        else $error("divider finished outside a waiting state");

    a_load_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result register loaded outside FINISH");

    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_in_reg) |-> (out_val_reg == '0))
        else $error("outside result carries a nonzero value");

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the heightmap triangle interpolator. Node writes
// and position queries go to the request channel from a queue, with random
// gaps. A clocked predictor tracks the node grid and the registers and
// computes each query's result. A monitor checks every result beat against
// the oldest expected value, with random and long stalls on the result side.
// ---------------------------------------------------------------------------
module tb_top;
    import hti_pkg::*;

    localparam int ROW        = 257;
    localparam int NODES      = ROW * ROW;
    localparam int HOLD_LEN   = 400;
    localparam int DOG_LIMIT  = 6000;
    localparam int WRITE_WAIT = 8;
    localparam int DRAIN_WAIT = 200;
    localparam longint ONE    = 65536;

    typedef struct {
        mode_t              mode;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] hgt;
        int                 gap;   // idle cycles before this beat
    } req_beat_t;

    typedef struct {
        reg_idx_t    idx;
        logic [31:0] data;
    } reg_beat_t;

    typedef struct {
        logic signed [31:0] value;
        logic               in_grid;
    } lookup_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hti_cfg_if cfg_if ();
    hti_in_if  req_if ();
    hti_out_if rsp_if ();

    heightmap_triangle_interpolator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #1 clk = ~clk;

    // Stimulus queues and the store of expected lookups.
    req_beat_t req_todo[$];
    reg_beat_t reg_todo[$];
    lookup_t   lookups_due[$];

    // Predictor state: node grid and registers as the block sees them.
    logic signed [31:0] grid_h[NODES];
    bit                 grid_set[NODES];   // generator side: node written
    longint             g_ox, g_oy, g_cs;
    int                 g_cx, g_cy;

    int  errors = 0;
    bit  calm = 1'b0;          // phase without idle gaps
    int  hold_asked = 0;
    int  hold_seen = 0;

    function automatic int in_use(int c);
        return (c > 256) ? 256 : c;
    endfunction

    function automatic bit locate(longint px, longint py,
                                  output longint ix, output longint iy);
        longint dx, dy;
        dx = px - g_ox;
        dy = py - g_oy;
        ix = 0;
        iy = 0;
        if (g_cs == 0 || dx < 0 || dy < 0)
            return 1'b0;
        ix = dx / g_cs;
        iy = dy / g_cs;
        return (ix < in_use(g_cx)) && (iy < in_use(g_cy));
    endfunction

    function automatic longint node_h(longint x, longint y);
        return longint'(grid_h[y * ROW + x]);
    endfunction

    // Slope: diff * 1.0 / cell size, rounded half away from zero.
    function automatic longint slope_of(longint diff);
        longint mag, q;
        mag = (diff < 0 ? -diff : diff) <<< 16;
        q = (2 * mag + g_cs) / (2 * g_cs);
        return (diff < 0) ? -q : q;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Work out what one accepted beat does to the grid and what it returns.
    function automatic void predict_lookup(mode_t m, logic signed [31:0] cx,
                                           logic signed [31:0] cy,
                                           logic signed [31:0] hgt);
        longint ix, iy, dx, dy, fx, fy, h00, h10, h01, h11, r;
        lookup_t res;
        if (m == MODE_WRITE) begin
            // node index taken unsigned; beyond the cells in use is dropped
            if ({1'b0, cx} <= in_use(g_cx) && {1'b0, cy} <= in_use(g_cy))
                grid_h[int'(cy) * ROW + int'(cx)] = hgt;
            return;
        end
        res.value = '0;
        res.in_grid = 1'b0;
        if (locate(longint'(cx), longint'(cy), ix, iy)) begin
            dx = longint'(cx) - g_ox;
            dy = longint'(cy) - g_oy;
            fx = ((dx % g_cs) <<< 16) / g_cs;
            fy = ((dy % g_cs) <<< 16) / g_cs;
            h00 = node_h(ix, iy);
            h10 = node_h(ix + 1, iy);
            h01 = node_h(ix, iy + 1);
            h11 = node_h(ix + 1, iy + 1);
            if (fx + fy < ONE) begin
                case (m)
                    MODE_HEIGHT:
                        r = (h00 * ONE + fx * (h10 - h00) + fy * (h01 - h00) + 32768) >>> 16;
                    MODE_SLOPE_X: r = slope_of(h10 - h00);
                    default:      r = slope_of(h01 - h00);
                endcase
            end else begin
                case (m)
                    MODE_HEIGHT:
                        r = (h11 * ONE + (ONE - fx) * (h01 - h11)
                             + (ONE - fy) * (h10 - h11) + 32768) >>> 16;
                    MODE_SLOPE_X: r = slope_of(h11 - h01);
                    default:      r = slope_of(h11 - h10);
                endcase
            end
            res.value = clamp32(r);
            res.in_grid = 1'b1;
        end
        lookups_due.push_back(res);
    endfunction

    function automatic int draw_gap();
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic void queue_beat(mode_t m, longint x, longint y, logic [31:0] h);
        req_beat_t b;
        b.mode = m;
        b.cx = x[31:0];
        b.cy = y[31:0];
        b.hgt = h;
        b.gap = draw_gap();
        req_todo.push_back(b);
    endfunction

    function automatic void queue_write(longint x, longint y, logic [31:0] h);
        logic [32:0] ux, uy;
        ux = {1'b0, x[31:0]};
        uy = {1'b0, y[31:0]};
        if (ux <= in_use(g_cx) && uy <= in_use(g_cy))
            grid_set[int'(uy) * ROW + int'(ux)] = 1'b1;
        queue_beat(MODE_WRITE, x, y, h);
    endfunction

    // Queue a query unless the position is not 32-bit or would read a
    // node that was never written.
    function automatic bit try_query(mode_t m, longint px, longint py);
        longint ix, iy;
        if (px > 64'sd2147483647 || px < -64'sd2147483648 ||
            py > 64'sd2147483647 || py < -64'sd2147483648)
            return 1'b0;
        if (locate(px, py, ix, iy)) begin
            if (!grid_set[iy * ROW + ix] || !grid_set[iy * ROW + ix + 1] ||
                !grid_set[(iy + 1) * ROW + ix] || !grid_set[(iy + 1) * ROW + ix + 1])
                return 1'b0;
        end
        queue_beat(m, px, py, 32'h0);
        return 1'b1;
    endfunction

    function automatic logic [31:0] draw_height();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic mode_t draw_query_mode();
        case ($urandom_range(1, 3))
            1: return MODE_HEIGHT;
            2: return MODE_SLOPE_X;
            default: return MODE_SLOPE_Y;
        endcase
    endfunction

    // Node indexes exercised along one axis: all of them for small grids,
    // both ends for large ones.
    function automatic void axis_nodes(int n, ref int list[$]);
        list.delete();
        if (n <= 12) begin
            for (int i = 0; i <= n; i++)
                list.push_back(i);
        end else begin
            list = '{0, 1, 2, n - 2, n - 1, n};
        end
    endfunction

    // ---- config driver: one beat per register write ------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cfg_if.valid <= 1'b0;
            cfg_if.index <= REG_ORIGIN_X;
            cfg_if.data  <= '0;
        end else begin
            if (cfg_if.valid && cfg_if.ready) begin
                case (cfg_if.index)
                    REG_ORIGIN_X:  g_ox = longint'(signed'(cfg_if.data));
                    REG_ORIGIN_Y:  g_oy = longint'(signed'(cfg_if.data));
                    REG_CELL_SIZE: g_cs = longint'(cfg_if.data[30:0]);
                    REG_CELLS_X:   g_cx = int'(cfg_if.data[8:0]);
                    REG_CELLS_Y:   g_cy = int'(cfg_if.data[8:0]);
                    default: ;
                endcase
            end
            if (!cfg_if.valid || cfg_if.ready) begin
                if (reg_todo.size() > 0) begin
                    reg_beat_t rb;
                    rb = reg_todo.pop_front();
                    cfg_if.valid <= 1'b1;
                    cfg_if.index <= rb.idx;
                    cfg_if.data  <= rb.data;
                end else begin
                    cfg_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---- request driver: predicts on each accepted beat ---------------------
    int gap_left;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_if.valid     <= 1'b0;
            req_if.mode      <= MODE_WRITE;
            req_if.coord_x   <= '0;
            req_if.coord_y   <= '0;
            req_if.height_in <= '0;
            gap_left = 0;
        end else begin
            if (req_if.valid && req_if.ready)
                predict_lookup(req_if.mode, req_if.coord_x, req_if.coord_y,
                               req_if.height_in);
            if (!req_if.valid || req_if.ready) begin
                if (req_todo.size() > 0 && gap_left < req_todo[0].gap) begin
                    gap_left++;
                    req_if.valid <= 1'b0;
                end else if (req_todo.size() > 0) begin
                    req_beat_t b;
                    b = req_todo.pop_front();
                    gap_left = 0;
                    req_if.valid     <= 1'b1;
                    req_if.mode      <= b.mode;
                    req_if.coord_x   <= b.cx;
                    req_if.coord_y   <= b.cy;
                    req_if.height_in <= b.hgt;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---- result monitor: random stalls plus one long hold-off on request ----
    int wait_left;
    int stall_left;
    int next_wait;

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
            wait_left = 0;
            stall_left = 0;
        end else begin
            next_wait = wait_left;
            if (rsp_if.valid && rsp_if.ready) begin
                if (lookups_due.size() == 0) begin
                    $error("result beat with nothing expected: value_out %0d inside_res %0b",
                           rsp_if.value_out, rsp_if.inside_res);
                    errors++;
                end else begin
                    lookup_t e;
                    e = lookups_due.pop_front();
                    if (rsp_if.value_out !== e.value) begin
                        $error("value_out expected %0d actual %0d", e.value, rsp_if.value_out);
                        errors++;
                    end
                    if (rsp_if.inside_res !== e.in_grid) begin
                        $error("inside_res expected %0b actual %0b", e.in_grid,
                               rsp_if.inside_res);
                        errors++;
                    end
                end
                next_wait = draw_gap();
            end
            if (hold_seen != hold_asked) begin
                hold_seen = hold_asked;
                stall_left = HOLD_LEN;
                rsp_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else if (next_wait > 0) begin
                wait_left = next_wait - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                wait_left = 0;
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // ---- watchdog: cycles with work outstanding and no beat on any channel --
    int quiet = 0;

    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet <= 0;
        else if (req_todo.size() > 0 || lookups_due.size() > 0 || req_if.valid ||
                 reg_todo.size() > 0)
            quiet <= quiet + 1;
        if (quiet >= DOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---- phases -------------------------------------------------------------
    task automatic wait_quiet();
        while (req_todo.size() > 0 || req_if.valid || lookups_due.size() > 0 ||
               reg_todo.size() > 0 || cfg_if.valid)
            @(posedge clk);
        // a trailing node write gives no result; let it land
        repeat (WRITE_WAIT) @(posedge clk);
    endtask

    task automatic set_regs(longint ox, longint oy, longint cs, int cx, int cy);
        reg_beat_t rb;
        wait_quiet();
        rb.idx = REG_ORIGIN_X;  rb.data = ox[31:0];  reg_todo.push_back(rb);
        rb.idx = REG_ORIGIN_Y;  rb.data = oy[31:0];  reg_todo.push_back(rb);
        rb.idx = REG_CELL_SIZE; rb.data = cs[31:0];  reg_todo.push_back(rb);
        rb.idx = REG_CELLS_X;   rb.data = cx;        reg_todo.push_back(rb);
        rb.idx = REG_CELLS_Y;   rb.data = cy;        reg_todo.push_back(rb);
        wait_quiet();
    endtask

    // Fill the exercised nodes, then a random mix: mostly queries aimed at
    // written cells, some raw noise, some node rewrites and dropped writes.
    task automatic random_phase(int count);
        int xs[$], ys[$];
        longint ix, iy, off, px, py;
        int n, pick;
        bit ok;
        axis_nodes(in_use(g_cx), xs);
        axis_nodes(in_use(g_cy), ys);
        foreach (xs[i])
            foreach (ys[j])
                queue_write(xs[i], ys[j], draw_height());
        n = 0;
        while (n < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                queue_write(xs[$urandom_range(0, xs.size() - 1)],
                            ys[$urandom_range(0, ys.size() - 1)], draw_height());
                n++;
            end else if (pick < 16) begin
                queue_write(longint'(signed'($urandom)), $urandom_range(0, 300),
                            draw_height());
                n++;
            end else if (pick < 28) begin
                if (try_query(draw_query_mode(), longint'(signed'($urandom)),
                              longint'(signed'($urandom))))
                    n++;
            end else begin
                ok = 1'b0;
                for (int t = 0; t < 8 && !ok; t++) begin
                    ix = xs[$urandom_range(0, xs.size() - 1)];
                    iy = ys[$urandom_range(0, ys.size() - 1)];
                    off = (g_cs > 0) ? $urandom_range(0, g_cs - 1) : 0;
                    px = g_ox + ix * g_cs + (($urandom_range(0, 7) == 0) ? 0 : off);
                    off = (g_cs > 0) ? $urandom_range(0, g_cs - 1) : 0;
                    py = g_oy + iy * g_cs + (($urandom_range(0, 7) == 0) ? g_cs - 1 : off);
                    ok = try_query(draw_query_mode(), px, py);
                end
                if (!ok)
                    ok = try_query(draw_query_mode(), g_ox - 1, g_oy);
                if (ok)
                    n++;
            end
        end
    endtask

    initial begin
        bit ok;
        for (int i = 0; i < NODES; i++)
            grid_set[i] = 1'b0;
        g_ox = 0;
        g_oy = 0;
        g_cs = longint'(CS_RESET);
        g_cx = int'(CNT_RESET);
        g_cy = int'(CNT_RESET);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset settings: one-unit cells, 256 x 256.
        calm = 1'b1;
        queue_write(0, 0, 32'h7fff_ffff);
        queue_write(1, 0, 32'h8000_0000);
        queue_write(0, 1, 32'h0000_0000);
        queue_write(1, 1, 32'h1234_5678);
        queue_write(255, 255, 32'hffff_0000);
        queue_write(256, 255, 32'h0001_8000);
        queue_write(255, 256, 32'h8000_0000);
        queue_write(256, 256, 32'h7fff_ffff);
        queue_write(257, 0, 32'h5555_5555);            // past last node: dropped
        queue_write(0, -1, 32'haaaa_aaaa);             // index as unsigned: dropped
        ok = try_query(MODE_HEIGHT, 0, 0);             // exact node
        ok = try_query(MODE_HEIGHT, 32'h8000, 32'h8000);  // diagonal: upper triangle
        ok = try_query(MODE_HEIGHT, 32'h7fff, 32'h8000);  // just in lower triangle
        ok = try_query(MODE_SLOPE_X, 32'h100, 32'h100);   // saturating slope
        ok = try_query(MODE_SLOPE_Y, 32'h100, 32'h100);
        ok = try_query(MODE_SLOPE_X, 32'hc000, 32'hc000);
        ok = try_query(MODE_SLOPE_Y, 32'hc000, 32'hc000);
        ok = try_query(MODE_HEIGHT, 32'h00ff_ffff, 32'h00ff_ffff);  // far corner
        ok = try_query(MODE_SLOPE_X, 32'h00ff_8000, 32'h00ff_0001);
        ok = try_query(MODE_HEIGHT, 32'h0100_0000, 0);  // one past the grid
        ok = try_query(MODE_SLOPE_Y, 0, 32'h0100_0000);
        ok = try_query(MODE_HEIGHT, -1, 0);             // left of origin
        ok = try_query(MODE_SLOPE_X, 0, 32'sh8000_0000);
        ok = try_query(MODE_HEIGHT, 32'sh7fff_ffff, 32'sh7fff_ffff);
        wait_quiet();

        calm = 1'b0;
        hold_asked++;       // long result-side stall; the block backs up
        random_phase(120);

        set_regs(32'h0003_0000, -32'sh0002_8000, 32'h0001_8000, 4, 6);
        random_phase(150);

        calm = 1'b1;
        set_regs(-64'sd2147483648, -64'sd2147483648, 1, 1, 1);
        random_phase(80);

        calm = 1'b0;
        set_regs(64'sd2147483647, 0, 31'h7fff_ffff, 511, 0);   // no rows in use
        random_phase(30);

        set_regs(0, 0, 0, 8, 8);                               // zero cell size
        random_phase(25);

        set_regs(-1000000, 12345, 31'h7fff_ffff, 300, 3);
        random_phase(80);

        set_regs(0, 0, 3, 8, 8);                               // odd size: rounding without ties
        random_phase(120);

        hold_asked++;
        set_regs(32'h1234_0000, -32'sh0040_0000, 32'h3000, 256, 256);
        random_phase(120);

        wait_quiet();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== heightmap_triangle_interpolator.f =====
design/hti_pkg.sv
design/hti_cfg_if.sv
design/hti_in_if.sv
design/hti_out_if.sv
design/hti_div.sv
design/heightmap_triangle_interpolator.sv
tb/tb_top.sv
